>>> hw/rtl/pci_bridge_transaction_decode_top_assert.svh
// Assertion macros used by the top-level RTL file of the bridge decoder.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef PCI_BRIDGE_TRANSACTION_DECODE_TOP_ASSERT_SVH
`define PCI_BRIDGE_TRANSACTION_DECODE_TOP_ASSERT_SVH

`ifndef SYNTH
`define PTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PTD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

  // Transaction codes on the input word.
  localparam logic [2:0] OP_IO_RD  = 3'd0;
  localparam logic [2:0] OP_IO_WR  = 3'd1;
  localparam logic [2:0] OP_MEM_RD = 3'd2;
  localparam logic [2:0] OP_MEM_WR = 3'd3;
  localparam logic [2:0] OP_CFG_RD = 3'd4;
  localparam logic [2:0] OP_CFG_WR = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_CONTROL    = 3'd0;
  localparam logic [2:0] REG_IO_BASE    = 3'd1;
  localparam logic [2:0] REG_IO_TOP     = 3'd2;
  localparam logic [2:0] REG_MEM_BOTTOM = 3'd3;
  localparam logic [2:0] REG_MEM_TOP    = 3'd4;
  localparam logic [2:0] REG_PF_BASE    = 3'd5;
  localparam logic [2:0] REG_PF_LIMIT   = 3'd6;
  localparam logic [2:0] REG_BUS_NUMS   = 3'd7;

  // Control bit positions.
  localparam int unsigned CB_IOEN   = 0;
  localparam int unsigned CB_MEMEN  = 1;
  localparam int unsigned CB_MASTER = 2;
  localparam int unsigned CB_ISA    = 3;
  localparam int unsigned CB_VGA    = 4;
  localparam int unsigned CB_SNOOP  = 5;

  localparam logic [31:0] IO_ALIAS_MASK = 32'hFFFF_03FF;
  localparam logic [31:0] VGA_IO_LO0    = 32'h0000_03B0;
  localparam logic [31:0] VGA_IO_HI0    = 32'h0000_03BB;
  localparam logic [31:0] VGA_IO_LO1    = 32'h0000_03C0;
  localparam logic [31:0] VGA_IO_HI1    = 32'h0000_03DF;
  localparam logic [31:0] SNOOP_A       = 32'h0000_03C6;
  localparam logic [31:0] SNOOP_B       = 32'h0000_03C8;
  localparam logic [31:0] SNOOP_C       = 32'h0000_03C9;
  localparam logic [63:0] VGA_MEM_LO    = 64'h0000_0000_000A_0000;
  localparam logic [63:0] VGA_MEM_HI    = 64'h0000_0000_000B_FFFF;
  localparam logic [4:0]  SPECIAL_DEV   = 5'h1F;
  localparam logic [2:0]  SPECIAL_FN    = 3'd7;
  localparam logic [5:0]  SPECIAL_REG   = 6'd0;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_FWD     = 3'd1,
    ACT_TYPE0   = 3'd2,
    ACT_SPECIAL = 3'd3,
    ACT_TYPE1   = 3'd4
  } action_e;

  localparam logic DEST_SEC = 1'b0;
  localparam logic DEST_PRI = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic        from_secondary;
    logic [63:0] address;
    logic [7:0]  bus_num;
    logic [4:0]  device_num;
    logic [2:0]  function_num;
    logic [5:0]  reg_index;
  } in_item_t;

  typedef struct packed {
    action_e action;
    logic    destination;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  control_bits;
    logic [31:0] io_base;
    logic [31:0] io_top;
    logic [31:0] mem_bottom;
    logic [31:0] mem_top;
    logic [63:0] prefetch_base;
    logic [63:0] prefetch_limit;
    logic [23:0] bus_numbers;
  } cfg_regs_t;

endpackage

>>> hw/rtl/ptd_if.sv
`timescale 1ns / 1ps

interface ptd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        from_secondary;
  logic [63:0] address;
  logic [7:0]  bus_num;
  logic [4:0]  device_num;
  logic [2:0]  function_num;
  logic [5:0]  reg_index;

  modport source (
    output valid, op, from_secondary, address, bus_num, device_num, function_num,
           reg_index,
    input  ready
  );
  modport sink (
    input  valid, op, from_secondary, address, bus_num, device_num, function_num,
           reg_index,
    output ready
  );
endinterface

interface ptd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       destination;

  modport source (output valid, action, destination, input ready);
  modport sink (input valid, action, destination, output ready);
endinterface

>>> hw/rtl/ptd_cfg_regs.sv
`timescale 1ns / 1ps

module ptd_cfg_regs
  import ptd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output cfg_regs_t   cfg_o
);

  cfg_regs_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CONTROL:    cfg_d.control_bits   = cfg_wdata_i[5:0];
        REG_IO_BASE:    cfg_d.io_base        = cfg_wdata_i[31:0];
        REG_IO_TOP:     cfg_d.io_top         = cfg_wdata_i[31:0];
        REG_MEM_BOTTOM: cfg_d.mem_bottom     = cfg_wdata_i[31:0];
        REG_MEM_TOP:    cfg_d.mem_top        = cfg_wdata_i[31:0];
        REG_PF_BASE:    cfg_d.prefetch_base  = cfg_wdata_i;
        REG_PF_LIMIT:   cfg_d.prefetch_limit = cfg_wdata_i;
        REG_BUS_NUMS:   cfg_d.bus_numbers    = cfg_wdata_i[23:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/ptd_decode.sv
`timescale 1ns / 1ps

module ptd_decode
  import ptd_pkg::*;
(
  input  in_item_t  item_i,
  input  cfg_regs_t cfg_i,
  output out_item_t result_o
);

  logic [63:0] a;
  logic [31:0] alias_addr;
  logic        is_write;
  logic        upper_zero;
  logic        isa_applies;
  logic        in_io_win;
  logic        mem_hit;
  logic        io_down, io_up, mem_down, mem_up;
  logic        vga_io, snoop_hit, vga_mem;
  logic        special;
  logic [7:0]  pbus, sbus, subus;
  action_e     act;

  assign a          = item_i.address;
  assign is_write   = item_i.op[0];
  assign upper_zero = (a[63:32] == 32'd0);
  assign alias_addr = a[31:0] & IO_ALIAS_MASK;
  assign isa_applies = cfg_i.control_bits[CB_ISA] && (a[63:16] == 48'd0);

  assign in_io_win = upper_zero && (a[31:0] >= cfg_i.io_base) && (a[31:0] <= cfg_i.io_top);

  assign vga_io = ((alias_addr >= VGA_IO_LO0) && (alias_addr <= VGA_IO_HI0)) ||
                  ((alias_addr >= VGA_IO_LO1) && (alias_addr <= VGA_IO_HI1));
  assign snoop_hit = (alias_addr == SNOOP_A) || (alias_addr == SNOOP_B) ||
                     (alias_addr == SNOOP_C);

  always_comb begin
    io_down = 1'b0;
    if (cfg_i.control_bits[CB_IOEN]) begin
      if (in_io_win) begin
        io_down = isa_applies ? (a[9:8] == 2'b00) : 1'b1;
      end else if (cfg_i.control_bits[CB_VGA]) begin
        io_down = vga_io;
      end else begin
        io_down = is_write && cfg_i.control_bits[CB_SNOOP] && snoop_hit;
      end
    end
  end

  assign io_up = cfg_i.control_bits[CB_MASTER] &&
                 (!in_io_win || (isa_applies && (a[9:8] != 2'b00)));

  // Dual address cycles decode against the 64-bit prefetchable window.
  assign mem_hit = upper_zero ?
                   ((a[31:0] >= cfg_i.mem_bottom) && (a[31:0] <= cfg_i.mem_top)) :
                   ((a >= cfg_i.prefetch_base) && (a <= cfg_i.prefetch_limit));
  assign vga_mem  = cfg_i.control_bits[CB_VGA] && (a >= VGA_MEM_LO) && (a <= VGA_MEM_HI);
  assign mem_down = cfg_i.control_bits[CB_MEMEN] && (mem_hit || vga_mem);
  assign mem_up   = cfg_i.control_bits[CB_MASTER] && !mem_hit;

  assign pbus  = cfg_i.bus_numbers[7:0];
  assign sbus  = cfg_i.bus_numbers[15:8];
  assign subus = cfg_i.bus_numbers[23:16];
  assign special = is_write && (item_i.device_num == SPECIAL_DEV) &&
                   (item_i.function_num == SPECIAL_FN) && (item_i.reg_index == SPECIAL_REG);

  always_comb begin
    act = ACT_NONE;
    case (item_i.op)
      OP_IO_RD, OP_IO_WR: begin
        if (item_i.from_secondary ? io_up : io_down) act = ACT_FWD;
      end
      OP_MEM_RD, OP_MEM_WR: begin
        if (item_i.from_secondary ? mem_up : mem_down) act = ACT_FWD;
      end
      OP_CFG_RD, OP_CFG_WR: begin
        if (!item_i.from_secondary) begin
          if (item_i.bus_num == sbus) begin
            act = special ? ACT_SPECIAL : ACT_TYPE0;
          end else if ((item_i.bus_num > sbus) && (item_i.bus_num <= subus)) begin
            act = ACT_TYPE1;
          end
        end else if ((item_i.bus_num < sbus) || (item_i.bus_num > subus)) begin
          if (item_i.bus_num == pbus) begin
            act = special ? ACT_SPECIAL : ACT_TYPE0;
          end else begin
            act = ACT_TYPE1;
          end
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  assign result_o.action      = act;
  assign result_o.destination = ((act != ACT_NONE) && item_i.from_secondary) ? DEST_PRI
                                                                                : DEST_SEC;

endmodule

>>> hw/rtl/pci_bridge_transaction_decode_top.sv
`timescale 1ns / 1ps
`include "pci_bridge_transaction_decode_top_assert.svh"
// PCI-to-PCI bridge transaction decoder.
// in_chan carries one bus transaction per word (operation, side, address and
// configuration target); out_chan returns one decision word per transaction:
// the action taken and the bus it is forwarded to. Both use valid/ready and
// a word moves on a clock edge where both are high.
// Window, enable and bus-number registers are loaded through the cfg_* write
// port, one register per cycle with cfg_we_i high; the user must load them only
// while no transaction is in flight, as the block does not enforce it.
// A word accepted at one edge goes into the input register and is decoded by one
// pass of comparators out of it; its decision is captured in the result register
// and offered on out_chan from there. Throughput is one word per cycle, limited
// only by the result register draining.
// When out_chan stalls, the result register holds its word and the input
// register still takes one more word; in_chan.ready drops only when both
// registers are full. Reset empties both registers and clears all
// configuration registers to zero.
module pci_bridge_transaction_decode_top
  import ptd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  ptd_in_if.sink      in_chan,
  ptd_out_if.source   out_chan
);

  cfg_regs_t cfg;
  in_item_t  in_item;
  in_item_t  s1_item_q;
  logic      s1_valid_q, s1_valid_d;
  out_item_t dec_result;
  out_item_t out_item_q;
  logic      out_valid_q, out_valid_d;
  logic      out_adv, s1_ready, in_fire, s1_move;

  ptd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign in_item.op             = in_chan.op;
  assign in_item.from_secondary = in_chan.from_secondary;
  assign in_item.address        = in_chan.address;
  assign in_item.bus_num        = in_chan.bus_num;
  assign in_item.device_num     = in_chan.device_num;
  assign in_item.function_num   = in_chan.function_num;
  assign in_item.reg_index      = in_chan.reg_index;

  assign out_adv  = !out_valid_q || out_chan.ready;
  assign s1_ready = !s1_valid_q || out_adv;
  assign in_fire  = in_chan.valid && s1_ready;
  assign s1_move  = s1_valid_q && out_adv;

  assign in_chan.ready = s1_ready;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_move ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_q);

  ptd_decode u_decode (
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (dec_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item;
    end
    if (s1_move) begin
      out_item_q <= dec_result;
    end
  end

  assign out_chan.valid       = out_valid_q;
  assign out_chan.action      = out_item_q.action;
  assign out_chan.destination = out_item_q.destination;

  // An accepted word always lands in the input register.
  `PTD_ASSERT_NEXT(a_in_lands, clk_i, rst_ni, in_chan.valid && in_chan.ready, s1_valid_q)
  // A decoded word moves into a free or draining result register.
  `PTD_ASSERT_NEXT(a_s1_moves, clk_i, rst_ni, s1_valid_q && out_adv, out_valid_q)
  // An unclaimed transaction always reports the secondary bus.
  `PTD_ASSERT_SAME(a_none_dest, clk_i, rst_ni,
                   out_valid_q && (out_item_q.action == ACT_NONE),
                   out_item_q.destination == DEST_SEC)
  // The input side is only held off while both registers are full.
  `PTD_ASSERT_SAME(a_ready_full, clk_i, rst_ni, !in_chan.ready,
                   s1_valid_q && out_valid_q && !out_chan.ready)

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import ptd_pkg::*;

  // Op codes the block must ignore.
  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;

  localparam int LONG_HOLD   = 80;
  localparam int DRAIN_GUARD = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  ptd_in_if  txn_if ();
  ptd_out_if dec_if ();

  pci_bridge_transaction_decode_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_chan     (txn_if),
    .out_chan    (dec_if)
  );

  cfg_regs_t bridge_regs;
  in_item_t  txn_backlog[$];
  out_item_t decisions_due[$];
  int        mismatches;
  logic      sender_gaps;
  logic      receiver_gaps;
  logic      sender_hold;
  int        send_gap;
  int        rx_stall;
  int        long_holds_wanted;
  int        long_holds_done;

  function automatic logic in_window(logic [63:0] a, logic [63:0] lo, logic [63:0] hi);
    return a >= lo && a <= hi;
  endfunction

  // Decision the bridge should take for one transaction under bridge_regs.
  function automatic out_item_t decode_txn(in_item_t t);
    logic [5:0]  ctrl;
    logic [31:0] alias_a;
    logic [7:0]  pri_bus;
    logic [7:0]  sec_bus;
    logic [7:0]  sub_bus;
    logic        isa_alias;
    logic        io_hit;
    logic        mem_hit;
    logic        special;
    logic        claim;
    out_item_t   r;
    ctrl    = bridge_regs.control_bits;
    alias_a = t.address[31:0] & IO_ALIAS_MASK;
    {sub_bus, sec_bus, pri_bus} = bridge_regs.bus_numbers;
    // The ISA rule covers only the 64K I/O space and looks at address bits 9:8.
    isa_alias = ctrl[CB_ISA] && t.address[63:16] == '0 && t.address[9:8] != 2'b00;
    io_hit = in_window(t.address, 64'(bridge_regs.io_base), 64'(bridge_regs.io_top));
    if (t.address[63:32] != '0) begin
      mem_hit = in_window(t.address, bridge_regs.prefetch_base, bridge_regs.prefetch_limit);
    end else begin
      mem_hit = in_window(t.address, 64'(bridge_regs.mem_bottom), 64'(bridge_regs.mem_top));
    end
    special = t.op == OP_CFG_WR && t.device_num == SPECIAL_DEV &&
              t.function_num == SPECIAL_FN && t.reg_index == SPECIAL_REG;
    claim = 1'b0;
    r.action = ACT_NONE;
    case (t.op)
      OP_IO_RD, OP_IO_WR: begin
        if (t.from_secondary) begin
          claim = ctrl[CB_MASTER] && (!io_hit || isa_alias);
        end else if (ctrl[CB_IOEN]) begin
          if (io_hit) begin
            claim = !isa_alias;
          end else if (ctrl[CB_VGA]) begin
            claim = in_window(64'(alias_a), 64'(VGA_IO_LO0), 64'(VGA_IO_HI0)) ||
                    in_window(64'(alias_a), 64'(VGA_IO_LO1), 64'(VGA_IO_HI1));
          end else begin
            claim = t.op == OP_IO_WR && ctrl[CB_SNOOP] &&
                    (alias_a == SNOOP_A || alias_a == SNOOP_B || alias_a == SNOOP_C);
          end
        end
      end
      OP_MEM_RD, OP_MEM_WR: begin
        if (t.from_secondary) begin
          claim = ctrl[CB_MASTER] && !mem_hit;
        end else begin
          claim = ctrl[CB_MEMEN] &&
                  (mem_hit || (ctrl[CB_VGA] && in_window(t.address, VGA_MEM_LO, VGA_MEM_HI)));
        end
      end
      OP_CFG_RD, OP_CFG_WR: begin
        if (!t.from_secondary) begin
          if (t.bus_num == sec_bus) begin
            r.action = special ? ACT_SPECIAL : ACT_TYPE0;
          end else if (t.bus_num > sec_bus && t.bus_num <= sub_bus) begin
            r.action = ACT_TYPE1;
          end
        end else if (t.bus_num < sec_bus || t.bus_num > sub_bus) begin
          if (t.bus_num == pri_bus) begin
            r.action = special ? ACT_SPECIAL : ACT_TYPE0;
          end else begin
            r.action = ACT_TYPE1;
          end
        end
      end
      default: ;
    endcase
    if (claim) begin
      r.action = ACT_FWD;
    end
    r.destination = (r.action != ACT_NONE && t.from_secondary) ? DEST_PRI : DEST_SEC;
    return r;
  endfunction

  function automatic logic [63:0] near(logic [63:0] x);
    return x + 64'($urandom_range(0, 2)) - 64'd1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t bus_txn(logic [2:0] op, logic sec, logic [63:0] addr);
    in_item_t t;
    t = '0;
    t.op = op;
    t.from_secondary = sec;
    t.address = addr;
    return t;
  endfunction

  function automatic in_item_t cfg_txn(logic [2:0] op, logic sec, logic [7:0] bus,
                                       logic [4:0] dev, logic [2:0] fn, logic [5:0] rg);
    in_item_t t;
    t = '0;
    t.op = op;
    t.from_secondary = sec;
    t.bus_num = bus;
    t.device_num = dev;
    t.function_num = fn;
    t.reg_index = rg;
    return t;
  endfunction

  // Addresses and bus numbers are steered toward window edges and the fixed ranges.
  function automatic in_item_t random_txn();
    in_item_t t;
    if ($urandom_range(0, 24) == 0) begin
      t.op = $urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B;
    end else begin
      t.op = 3'($urandom_range(0, 5));
    end
    t.from_secondary = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: t.address = {$urandom, $urandom};
      1: t.address = {32'h0, $urandom};
      2: t.address = near(64'(bridge_regs.io_base));
      3: t.address = near(64'(bridge_regs.io_top));
      4: t.address = near(64'($urandom_range(0, 1) ? bridge_regs.mem_bottom
                                                   : bridge_regs.mem_top));
      5: t.address = near($urandom_range(0, 1) ? bridge_regs.prefetch_base
                                               : bridge_regs.prefetch_limit);
      6: t.address = {48'h0, 6'($urandom), 10'($urandom_range(10'h3AE, 10'h3E1))};
      7: t.address = {48'h0, 16'($urandom)};
      8: t.address = near(64'h0000_0000_FFFF_FFFF);
      default: t.address = {44'h0, 20'($urandom_range(20'h9FFF0, 20'hC000F))};
    endcase
    if ($urandom_range(0, 7) == 0) begin
      t.address[63:16] = {$urandom, 16'($urandom)};
    end
    case ($urandom_range(0, 3))
      0: t.bus_num = 8'(near(64'(bridge_regs.bus_numbers[7:0])));
      1: t.bus_num = 8'(near(64'(bridge_regs.bus_numbers[15:8])));
      2: t.bus_num = 8'(near(64'(bridge_regs.bus_numbers[23:16])));
      default: t.bus_num = 8'($urandom);
    endcase
    t.device_num = 5'($urandom);
    t.function_num = 3'($urandom);
    t.reg_index = 6'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      t.device_num = SPECIAL_DEV;
      t.function_num = SPECIAL_FN;
      t.reg_index = SPECIAL_REG;
    end
    return t;
  endfunction

  function automatic cfg_regs_t random_settings();
    cfg_regs_t  s;
    logic [7:0] sec_bus;
    s.control_bits = 6'($urandom);
    if ($urandom_range(0, 1) != 0) begin
      s.io_base = $urandom & 32'hFFFF_F000;
    end else begin
      s.io_base = {16'h0, 4'($urandom), 12'h0};
    end
    if ($urandom_range(0, 5) == 0) begin
      s.io_top = $urandom;
    end else begin
      s.io_top = s.io_base + $urandom_range(0, 32'h2FFF);
    end
    s.mem_bottom = ($urandom_range(0, 3) == 0) ? $urandom : {12'($urandom), 20'h0};
    if ($urandom_range(0, 5) == 0) begin
      s.mem_top = $urandom;
    end else begin
      s.mem_top = s.mem_bottom + {8'h0, 4'($urandom), 20'hFFFFF};
    end
    if ($urandom_range(0, 3) == 0) begin
      s.prefetch_base = {$urandom, $urandom};
    end else begin
      s.prefetch_base = {28'h0, 4'($urandom_range(1, 15)), $urandom};
    end
    if ($urandom_range(0, 5) == 0) begin
      s.prefetch_limit = {$urandom, $urandom};
    end else begin
      s.prefetch_limit = s.prefetch_base + {32'h0, $urandom};
    end
    sec_bus = 8'($urandom);
    s.bus_numbers = {sec_bus + 8'($urandom_range(0, 6)), sec_bus, 8'($urandom)};
    return s;
  endfunction

  task automatic load_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
  endtask

  task automatic apply_settings(cfg_regs_t s);
    load_reg(REG_CONTROL, 64'(s.control_bits));
    load_reg(REG_IO_BASE, 64'(s.io_base));
    load_reg(REG_IO_TOP, 64'(s.io_top));
    load_reg(REG_MEM_BOTTOM, 64'(s.mem_bottom));
    load_reg(REG_MEM_TOP, 64'(s.mem_top));
    load_reg(REG_PF_BASE, s.prefetch_base);
    load_reg(REG_PF_LIMIT, s.prefetch_limit);
    load_reg(REG_BUS_NUMS, 64'(s.bus_numbers));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bridge_regs = s;
  endtask

  // Sampled on the falling edge, where every queue and handshake signal is settled.
  task automatic drain();
    int guard;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while ((txn_backlog.size() != 0 || txn_if.valid || decisions_due.size() != 0) &&
               guard < DRAIN_GUARD);
    if (txn_backlog.size() != 0 || txn_if.valid || decisions_due.size() != 0) begin
      $error("stuck with %0d words unsent and %0d decisions outstanding",
             txn_backlog.size(), decisions_due.size());
      mismatches++;
      decisions_due.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Sender: one word per handshake, with an optional gap after each accepted word.
  always @(posedge clk_i) begin : feeder
    in_item_t w;
    if (!rst_ni) begin
      txn_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (!txn_if.valid || txn_if.ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        txn_if.valid <= 1'b0;
      end else if (txn_backlog.size() != 0 && !sender_hold) begin
        w = txn_backlog.pop_front();
        txn_if.op             <= w.op;
        txn_if.from_secondary <= w.from_secondary;
        txn_if.address        <= w.address;
        txn_if.bus_num        <= w.bus_num;
        txn_if.device_num     <= w.device_num;
        txn_if.function_num   <= w.function_num;
        txn_if.reg_index      <= w.reg_index;
        txn_if.valid          <= 1'b1;
        send_gap <= sender_gaps ? gap_len() : 0;
      end else begin
        txn_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dec_if.ready <= 1'b0;
      rx_stall <= 0;
      long_holds_done <= 0;
    end else if (long_holds_done != long_holds_wanted) begin
      long_holds_done <= long_holds_wanted;
      rx_stall <= LONG_HOLD;
      dec_if.ready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      dec_if.ready <= 1'b0;
    end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
      rx_stall <= gap_len();
      dec_if.ready <= 1'b0;
    end else begin
      dec_if.ready <= 1'b1;
    end
  end

  // The decision word is checked before the new word is predicted; since a word passes
  // through the input and result registers first, they can never belong to the same transaction.
  always @(posedge clk_i) begin : scoreboard
    out_item_t want;
    in_item_t  seen;
    if (rst_ni) begin
      if (dec_if.valid && dec_if.ready) begin
        if (decisions_due.size() == 0) begin
          $error("decision word with nothing outstanding: action %0d destination %0d",
                 dec_if.action, dec_if.destination);
          mismatches++;
        end else begin
          want = decisions_due.pop_front();
          if (dec_if.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, dec_if.action);
            mismatches++;
          end
          if (dec_if.destination !== want.destination) begin
            $error("destination: expected %0d, got %0d", want.destination,
                   dec_if.destination);
            mismatches++;
          end
        end
      end
      if (txn_if.valid && txn_if.ready) begin
        seen.op             = txn_if.op;
        seen.from_secondary = txn_if.from_secondary;
        seen.address        = txn_if.address;
        seen.bus_num        = txn_if.bus_num;
        seen.device_num     = txn_if.device_num;
        seen.function_num   = txn_if.function_num;
        seen.reg_index      = txn_if.reg_index;
        decisions_due.push_back(decode_txn(seen));
      end
    end
  end

  initial begin : stimulus
    cfg_regs_t s;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_CONTROL;
    cfg_wdata_i = '0;
    txn_if.valid = 1'b0;
    txn_if.op = OP_IO_RD;
    txn_if.from_secondary = 1'b0;
    txn_if.address = '0;
    txn_if.bus_num = '0;
    txn_if.device_num = '0;
    txn_if.function_num = '0;
    txn_if.reg_index = '0;
    dec_if.ready = 1'b0;
    bridge_regs = '0;
    mismatches = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    sender_hold = 1'b0;
    long_holds_wanted = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers as they come out of reset.
    repeat (20) txn_backlog.push_back(random_txn());
    drain();

    // ISA aliasing, palette snoop, both memory windows and the bus-number decode.
    s = '0;
    s.control_bits[CB_IOEN]   = 1'b1;
    s.control_bits[CB_MEMEN]  = 1'b1;
    s.control_bits[CB_MASTER] = 1'b1;
    s.control_bits[CB_ISA]    = 1'b1;
    s.control_bits[CB_SNOOP]  = 1'b1;
    s.io_base        = 32'h0000_1000;
    s.io_top         = 32'h0000_1FFF;
    s.mem_bottom     = 32'h8000_0000;
    s.mem_top        = 32'h8FFF_FFFF;
    s.prefetch_base  = 64'h0000_0001_0000_0000;
    s.prefetch_limit = 64'h0000_0001_FFFF_FFFF;
    s.bus_numbers    = {8'h05, 8'h01, 8'h00};
    apply_settings(s);
    txn_backlog.push_back(bus_txn(OP_IO_RD, 1'b0, 64'h1000));
    txn_backlog.push_back(bus_txn(OP_IO_WR, 1'b0, 64'h1100));
    txn_backlog.push_back(bus_txn(OP_IO_RD, 1'b1, 64'h1100));
    txn_backlog.push_back(bus_txn(OP_IO_RD, 1'b1, 64'h1C00));
    txn_backlog.push_back(bus_txn(OP_IO_WR, 1'b1, 64'h0));
    txn_backlog.push_back(bus_txn(OP_IO_WR, 1'b0, 64'h3C6));
    txn_backlog.push_back(bus_txn(OP_IO_WR, 1'b0, 64'h3C8));
    txn_backlog.push_back(bus_txn(OP_IO_RD, 1'b0, 64'h3C9));
    txn_backlog.push_back(bus_txn(OP_IO_WR, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
    txn_backlog.push_back(bus_txn(OP_MEM_RD, 1'b0, 64'h8000_0000));
    txn_backlog.push_back(bus_txn(OP_MEM_WR, 1'b1, 64'h7FFF_FFFF));
    txn_backlog.push_back(bus_txn(OP_MEM_RD, 1'b0, 64'h1_0000_0000));
    txn_backlog.push_back(bus_txn(OP_MEM_WR, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    txn_backlog.push_back(cfg_txn(OP_CFG_RD, 1'b0, 8'h01, SPECIAL_DEV, SPECIAL_FN, SPECIAL_REG));
    txn_backlog.push_back(cfg_txn(OP_CFG_WR, 1'b0, 8'h01, SPECIAL_DEV, SPECIAL_FN, SPECIAL_REG));
    txn_backlog.push_back(cfg_txn(OP_CFG_WR, 1'b0, 8'h05, 5'h1F, 3'h7, 6'h3F));
    txn_backlog.push_back(cfg_txn(OP_CFG_RD, 1'b0, 8'h06, 5'h00, 3'h0, 6'h00));
    txn_backlog.push_back(cfg_txn(OP_CFG_WR, 1'b1, 8'h00, SPECIAL_DEV, SPECIAL_FN, SPECIAL_REG));
    txn_backlog.push_back(cfg_txn(OP_CFG_RD, 1'b1, 8'hFF, 5'h1F, 3'h7, 6'h3F));
    txn_backlog.push_back(bus_txn(OP_RSVD_A, 1'b0, 64'h1000));
    txn_backlog.push_back(bus_txn(OP_RSVD_B, 1'b1, 64'h0));
    drain();

    // VGA I/O and memory ranges, including an aliased VGA I/O address.
    s.control_bits[CB_SNOOP] = 1'b0;
    s.control_bits[CB_VGA]   = 1'b1;
    apply_settings(s);
    txn_backlog.push_back(bus_txn(OP_IO_RD, 1'b0, 64'h3B0));
    txn_backlog.push_back(bus_txn(OP_IO_WR, 1'b0, 64'h3DF));
    txn_backlog.push_back(bus_txn(OP_IO_RD, 1'b0, 64'h3E0));
    txn_backlog.push_back(bus_txn(OP_IO_RD, 1'b0, 64'h07BB));
    txn_backlog.push_back(bus_txn(OP_MEM_RD, 1'b0, 64'hA_0000));
    txn_backlog.push_back(bus_txn(OP_MEM_RD, 1'b0, 64'hC_0000));
    drain();

    // The sender keeps offering while the receiver holds off, so both stages fill.
    apply_settings(random_settings());
    sender_gaps <= 1'b0;
    receiver_gaps <= 1'($urandom_range(0, 1));
    repeat (40) txn_backlog.push_back(random_txn());
    long_holds_wanted <= long_holds_wanted + 1;
    drain();

    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin
          s = '1;
          s.io_base = 32'hFFFF_F000;
        end
        1: begin
          s = '0;
          s.control_bits = '1;
        end
        2: begin
          // Every window has its base above its limit.
          s.control_bits   = '1;
          s.io_base        = 32'h0000_2000;
          s.io_top         = 32'h0000_1FFF;
          s.mem_bottom     = 32'h4000_0000;
          s.mem_top        = 32'h3FFF_FFFF;
          s.prefetch_base  = 64'h0000_0002_0000_0000;
          s.prefetch_limit = 64'h0000_0001_FFFF_FFFF;
          s.bus_numbers    = {8'h10, 8'h20, 8'h30};
        end
        default: s = random_settings();
      endcase
      apply_settings(s);
      if (k == 3) begin
        sender_gaps <= 1'b0;
        receiver_gaps <= 1'b0;
      end else begin
        sender_gaps <= 1'($urandom_range(0, 3) != 0);
        receiver_gaps <= 1'($urandom_range(0, 3) != 0);
      end
      repeat (55) txn_backlog.push_back(random_txn());
      if (k == 4) begin
        // Stop sending midway until every outstanding decision is back.
        repeat (20) @(negedge clk_i);
        sender_hold = 1'b1;
        while (decisions_due.size() != 0 || txn_if.valid) @(negedge clk_i);
        sender_hold = 1'b0;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
